// File: rtl/core/midi_message_parser_macros.svh
// ----------------------------------------------------------------------------
// midi message parser assertion macros
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef MIDI_MESSAGE_PARSER_MACROS_SVH
`define MIDI_MESSAGE_PARSER_MACROS_SVH
`ifndef SYNTHESIS
// property holds at every clock edge out of reset
`define MMP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// consequent holds in the cycle after the antecedent
`define MMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MMP_ASSERT(lbl, prop, msg)
`define MMP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/core/mmp_pkg.sv
// ----------------------------------------------------------------------------
// mmp_pkg
// types and constants shared by the midi message parser
// ----------------------------------------------------------------------------
package mmp_pkg;

  // message kinds reported on the result channel
  typedef enum logic [3:0] {
    KIND_NONE     = 4'd0,
    KIND_NOTE_ON  = 4'd1,
    KIND_NOTE_OFF = 4'd2,
    KIND_CC       = 4'd3,
    KIND_BEND     = 4'd4,
    KIND_PROGRAM  = 4'd5,
    KIND_CLOCK    = 4'd6,
    KIND_START    = 4'd7,
    KIND_SONGPOS  = 4'd8
  } msg_kind_t;

  // status byte upper nibbles
  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_NOTE_ON  = 4'h9;
  localparam logic [3:0] ST_CC       = 4'hB;
  localparam logic [3:0] ST_PROGRAM  = 4'hC;
  localparam logic [3:0] ST_BEND     = 4'hE;
  localparam logic [3:0] ST_SYSTEM   = 4'hF;

  // system message lower nibbles
  localparam logic [3:0] SYS_SONGPOS  = 4'h2;
  localparam logic [3:0] SYS_CLOCK    = 4'h8;
  localparam logic [3:0] SYS_START    = 4'hA;
  localparam logic [3:0] SYS_CONTINUE = 4'hB;
  localparam logic [3:0] SYS_STOP     = 4'hC;

  // data bytes still awaited
  localparam logic [1:0] LEFT_NONE = 2'd0;
  localparam logic [1:0] LEFT_ONE  = 2'd1;
  localparam logic [1:0] LEFT_TWO  = 2'd2;

  typedef struct packed {
    msg_kind_t   kind;
    logic [3:0]  chan;
    logic [1:0]  left;
    logic [7:0]  held;
    logic [7:0]  unknown;
  } mmp_state_t;

  typedef struct packed {
    msg_kind_t   kind;
    logic [3:0]  chan;
    logic [7:0]  first;
    logic [7:0]  second;
    logic [15:0] wide;
    logic [7:0]  unknown;
  } mmp_result_t;

endpackage

// File: rtl/core/mmp_decode.sv
// ----------------------------------------------------------------------------
// mmp_decode
// next parser state and result for one received byte
// ----------------------------------------------------------------------------
module mmp_decode import mmp_pkg::*; (
  input  logic [7:0]  byte_i,
  input  mmp_state_t  state_i,
  output mmp_state_t  state_o,
  output mmp_result_t result_o
);

  logic [3:0] hi;
  logic [3:0] lo;

  assign hi = byte_i[7:4];
  assign lo = byte_i[3:0];

  always_comb begin
    state_o  = state_i;
    result_o = '{kind: KIND_NONE, chan: 4'h0, first: 8'h00, second: 8'h00,
                 wide: 16'h0000, unknown: 8'h00};
    unique case (state_i.left)
      LEFT_NONE: begin
        unique case (hi)
          ST_NOTE_ON: begin
            state_o.kind = KIND_NOTE_ON;
            state_o.chan = lo;
            state_o.left = LEFT_TWO;
          end
          ST_NOTE_OFF: begin
            state_o.kind = KIND_NOTE_OFF;
            state_o.chan = lo;
            state_o.left = LEFT_TWO;
          end
          ST_CC: begin
            state_o.kind = KIND_CC;
            state_o.chan = lo;
            state_o.left = LEFT_TWO;
          end
          ST_BEND: begin
            state_o.kind = KIND_BEND;
            state_o.chan = lo;
            state_o.left = LEFT_TWO;
          end
          ST_PROGRAM: begin
            state_o.kind = KIND_PROGRAM;
            state_o.chan = lo;
            state_o.left = LEFT_ONE;
          end
          ST_SYSTEM: begin
            unique case (lo)
              SYS_CLOCK:   result_o.kind = KIND_CLOCK;
              SYS_START:   result_o.kind = KIND_START;
              SYS_SONGPOS: begin
                state_o.kind = KIND_SONGPOS;
                state_o.chan = 4'h0;
                state_o.left = LEFT_TWO;
              end
              SYS_CONTINUE, SYS_STOP: ; // ignored
              default:     state_o.unknown = byte_i;
            endcase
          end
          default: state_o.unknown = byte_i;
        endcase
      end
      LEFT_TWO: begin
        state_o.held = byte_i;
        state_o.left = LEFT_ONE;
      end
      default: begin
        // final data byte completes the message
        state_o.kind    = KIND_NONE;
        state_o.chan    = 4'h0;
        state_o.left    = LEFT_NONE;
        result_o.kind   = state_i.kind;
        result_o.chan   = state_i.chan;
        result_o.first  = state_i.held;
        result_o.second = byte_i;
        unique case (state_i.kind)
          KIND_PROGRAM: begin
            result_o.first  = byte_i;
            result_o.second = 8'h00;
          end
          KIND_NOTE_OFF: result_o.second = 8'h00;
          KIND_BEND, KIND_SONGPOS: begin
            result_o.wide = ({8'h00, byte_i} << 7) + {8'h00, state_i.held};
          end
          default: ;
        endcase
      end
    endcase
    result_o.unknown = state_o.unknown;
  end

endmodule

// File: rtl/core/mmp_out_stage.sv
// ----------------------------------------------------------------------------
// mmp_out_stage
// result register with valid/ready hand-off
// ----------------------------------------------------------------------------
module mmp_out_stage import mmp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load_i,
  input  mmp_result_t result_i,
  input  logic        ready_i,
  output logic        valid_o,
  output logic        free_o,
  output mmp_result_t result_o
);

  logic        valid_r;
  logic        valid_nxt;
  mmp_result_t result_r;

  // slot is free when empty or being drained this cycle
  assign free_o    = !valid_r || ready_i;
  assign valid_nxt = load_i || (valid_r && !ready_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      result_r <= result_i;
    end
  end

  assign valid_o  = valid_r;
  assign result_o = result_r;

endmodule

// File: rtl/core/midi_message_parser.sv
// ----------------------------------------------------------------------------
// midi_message_parser
// byte-wise midi message parser without running status
// ----------------------------------------------------------------------------
// Takes one received byte per transaction and gives exactly one result per
// byte, in the next cycle through a result register. A byte seen while idle is
// read as a status byte: note on, note off, control change and pitch bend
// then gather two data bytes, program change one, song position two; data
// bytes are taken as they come, with no test of bit 7. Clock and start are
// reported at once, stop and continue are dropped, and any other status is
// kept as the last unknown status. Results that do not complete a message
// report kind none. Throughput is one byte per clock: the decode is made of
// nibble compares plus one 16-bit add, and a new byte is taken whenever the
// result register is empty or its content is taken in the same cycle.
// ----------------------------------------------------------------------------
module midi_message_parser import mmp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_msg_kind,
  output logic [3:0]  out_channel,
  output logic [7:0]  out_data_first,
  output logic [7:0]  out_data_second,
  output logic [15:0] out_wide_value,
  output logic [7:0]  out_last_unknown
);

`include "midi_message_parser_macros.svh"

  mmp_state_t  state_r;
  mmp_state_t  state_nxt;
  mmp_result_t dec_result;
  mmp_result_t out_result;
  logic        accept;
  logic        slot_free;

  // a byte is taken whenever the result slot can hold its result
  assign in_ready = slot_free;
  assign accept   = in_valid && in_ready;

  // parser state: pending message, bytes still due, first data byte, unknown latch
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{kind: KIND_NONE, chan: 4'h0, left: LEFT_NONE, held: 8'h00,
                   unknown: 8'h00};
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  // status decode and message completion
  mmp_decode u_decode (
    .byte_i   (in_byte),
    .state_i  (state_r),
    .state_o  (state_nxt),
    .result_o (dec_result)
  );

  // result register towards the consumer
  mmp_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .load_i   (accept),
    .result_i (dec_result),
    .ready_i  (out_ready),
    .valid_o  (out_valid),
    .free_o   (slot_free),
    .result_o (out_result)
  );

  assign out_msg_kind     = out_result.kind;
  assign out_channel      = out_result.chan;
  assign out_data_first   = out_result.first;
  assign out_data_second  = out_result.second;
  assign out_wide_value   = out_result.wide;
  assign out_last_unknown = out_result.unknown;

  // byte counter never holds three
  `MMP_ASSERT(a_left_range, state_r.left != 2'd3, "byte counter out of range")
  // a waiting result is never overwritten by a new transaction
  `MMP_ASSERT(a_no_overwrite, !(out_valid && !out_ready && accept), "result overwritten")
  // note on status starts a two byte gather
  `MMP_ASSERT_NEXT(a_note_on_start,
    accept && state_r.left == LEFT_NONE && in_byte[7:4] == ST_NOTE_ON,
    state_r.left == LEFT_TWO && state_r.kind == KIND_NOTE_ON,
    "note on did not start gather")
  // wide value only carried by bend and song position
  `MMP_ASSERT(a_wide_kind,
    !out_valid || out_msg_kind == KIND_BEND || out_msg_kind == KIND_SONGPOS ||
    out_wide_value == 16'h0000, "wide value on wrong kind")

endmodule
